[hdl/bkvt_pkg.sv]
// Shared types, constants and the byte-mask helper function of the bucketed key-value table.
// Used by the slot store, the top level and the port checker; depends on nothing.
package bkvt_pkg;

   localparam int BUCKET_BITS      = 6;
   localparam int SLOTS_PER_BUCKET = 8;
   localparam int NUM_TABLES       = 2;
   localparam int VALUE_BYTES      = 8;

   localparam int NUM_BUCKETS   = 1 << BUCKET_BITS;
   localparam int TOTAL_SLOTS   = NUM_TABLES * NUM_BUCKETS * SLOTS_PER_BUCKET;
   localparam int SLOT_AW       = $clog2(TOTAL_SLOTS);
   localparam int SLOT_CW       = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;
   localparam int TBL_CW        = (NUM_TABLES > 1) ? $clog2(NUM_TABLES) : 1;
   // Address step from the last slot of a bucket to slot 0 of that bucket in the next copy.
   localparam int BUCKET_STRIDE = (NUM_BUCKETS - 1) * SLOTS_PER_BUCKET + 1;

   localparam int KEY_W = 256;
   localparam int VAL_W = 64;
   localparam int LEN_W = 4;
   localparam int ST_W  = 3;

   localparam logic [ST_W-1:0] STS_OK        = 3'd0;
   localparam logic [ST_W-1:0] STS_NOT_FOUND = 3'd1;
   localparam logic [ST_W-1:0] STS_TOO_SMALL = 3'd2;
   localparam logic [ST_W-1:0] STS_FULL      = 3'd3;
   localparam logic [ST_W-1:0] STS_TOO_LONG  = 3'd4;
   localparam logic [ST_W-1:0] STS_ZERO_KEY  = 3'd5;

   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic [LEN_W-1:0] len;
      logic [VAL_W-1:0] value;
   } bkvt_slot_type;

   typedef struct packed {
      logic               wr_en;
      logic               wr_key_only;
      logic [SLOT_AW-1:0] wr_addr;
      logic [SLOT_AW-1:0] rd_addr;
   } bkvt_mem_ctl_type;

   // Keeps the low len bytes of a value; len of eight or more keeps all of them.
   function automatic logic [VAL_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
      logic [VAL_W-1:0] m;
      m = '0;
      for (int i = 0; i < VAL_W / 8; i++) begin
         if (LEN_W'(i) < len) begin
            m[i*8 +: 8] = 8'hFF;
         end
      end
      return m;
   endfunction

endpackage

[hdl/bkvt_slot_store.sv]
// Slot storage of the key-value table: key, length and value arrays with one
// write port and one registered read port. Depends on bkvt_pkg.
module bkvt_slot_store import bkvt_pkg::*; (
   input  logic             clock,
   input  bkvt_mem_ctl_type ctl,
   input  bkvt_slot_type    wr_data,
   output bkvt_slot_type    rd_data
);

   logic [KEY_W-1:0] key_mem [TOTAL_SLOTS];
   logic [LEN_W-1:0] len_mem [TOTAL_SLOTS];
   logic [VAL_W-1:0] val_mem [TOTAL_SLOTS];

   logic [KEY_W-1:0] rd_key_ff;
   logic [LEN_W-1:0] rd_len_ff;
   logic [VAL_W-1:0] rd_val_ff;

   // The clearing pass only touches keys; length and value stay unwritten.
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         key_mem[ctl.wr_addr] <= wr_data.key;
         if (!ctl.wr_key_only) begin
            len_mem[ctl.wr_addr] <= wr_data.len;
            val_mem[ctl.wr_addr] <= wr_data.value;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_key_ff <= key_mem[ctl.rd_addr];
      rd_len_ff <= len_mem[ctl.rd_addr];
      rd_val_ff <= val_mem[ctl.rd_addr];
   end

   assign rd_data.key   = rd_key_ff;
   assign rd_data.len   = rd_len_ff;
   assign rd_data.value = rd_val_ff;

endmodule

[hdl/bucketed_key_value_table_top.sv]
// Top level of the bucketed key-value table: request capture, scan sequencer,
// result register. Depends on bkvt_pkg and bkvt_slot_store.
//
// The block stores entries under 256-bit keys in NUM_TABLES copies of
// 2^BUCKET_BITS buckets with SLOTS_PER_BUCKET slots each; the top BUCKET_BITS
// bits of req_key_word0 select the bucket. A write (req_cmd = 1) updates the
// first slot holding its key or fills the first empty one; a read (req_cmd = 0)
// stops at the first empty slot or at its key. After reset the block sweeps the
// key memory to zero, one slot per cycle; req_stall stays high during that
// sweep. One request is handled at a time. A request whose key is zero, or a
// write whose length is too long, goes to its result without a scan; any other
// scans the bucket in each copy in turn, slot by slot, until it stops or has
// examined every slot of the bucket in all NUM_TABLES copies. The scan is paced
// by the single read port of the slot memory and the single 256-bit key compare,
// which see one slot per cycle. The result register frees the scan engine: a new
// request is taken while an earlier result still waits for its transfer on the
// rsp_ side.
module bucketed_key_value_table_top import bkvt_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_cmd,
   input  logic [63:0]       req_key_word0,
   input  logic [63:0]       req_key_word1,
   input  logic [63:0]       req_key_word2,
   input  logic [63:0]       req_key_word3,
   input  logic [63:0]       req_value_in,
   input  logic [7:0]        req_value_len_in,
   input  logic [7:0]        req_buffer_capacity,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [ST_W-1:0]   rsp_status,
   output logic [VAL_W-1:0]  rsp_value_out,
   output logic [LEN_W-1:0]  rsp_value_len_out
);

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_SCAN  = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [SLOT_AW-1:0] clr_addr_ff, clr_addr_in;

   // Request held for the duration of the scan.
   logic               cmd_ff, cmd_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [VAL_W-1:0]   value_ff, value_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [7:0]         cap_ff, cap_in;

   // Position of the slot whose data the memory presents this cycle.
   logic [SLOT_AW-1:0] addr_ff, addr_in;
   logic [SLOT_CW-1:0] slot_ff, slot_in;
   logic [TBL_CW-1:0]  tbl_ff, tbl_in;

   logic [ST_W-1:0]    res_status_ff, res_status_in;
   logic [VAL_W-1:0]   res_value_ff, res_value_in;
   logic [LEN_W-1:0]   res_len_ff, res_len_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [ST_W-1:0]    rsp_status_ff, rsp_status_in;
   logic [VAL_W-1:0]   rsp_value_ff, rsp_value_in;
   logic [LEN_W-1:0]   rsp_len_ff, rsp_len_in;

   bkvt_mem_ctl_type   mem_ctl;
   bkvt_slot_type      mem_wr;
   bkvt_slot_type      mem_rd;

   logic [KEY_W-1:0]   req_key;
   logic [SLOT_AW-1:0] start_addr;
   logic [SLOT_AW-1:0] next_addr;
   logic               bucket_end;
   logic               last_slot;
   logic               key_eq;
   logic               slot_empty;
   logic               req_xfer;
   logic               out_free;

   bkvt_slot_store u_store (
      .clock   (clock),
      .ctl     (mem_ctl),
      .wr_data (mem_wr),
      .rd_data (mem_rd)
   );

   assign req_key    = {req_key_word0, req_key_word1, req_key_word2, req_key_word3};
   assign start_addr = SLOT_AW'(req_key_word0[63 -: BUCKET_BITS]) *
                       SLOT_AW'(SLOTS_PER_BUCKET);
   assign req_stall  = (state_ff != S_IDLE);
   assign req_xfer   = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // The shared compare unit: one stored key against the request key per cycle.
   assign key_eq     = (mem_rd.key == key_ff);
   assign slot_empty = (mem_rd.key == '0);

   assign bucket_end = (slot_ff == SLOT_CW'(SLOTS_PER_BUCKET - 1));
   assign last_slot  = bucket_end && (tbl_ff == TBL_CW'(NUM_TABLES - 1));
   assign next_addr  = bucket_end ? (addr_ff + SLOT_AW'(BUCKET_STRIDE))
                                  : (addr_ff + SLOT_AW'(1));

   // The memory is read one slot ahead so that a slot is checked every cycle.
   always_comb begin
      mem_ctl.wr_en       = 1'b0;
      mem_ctl.wr_key_only = 1'b0;
      mem_ctl.wr_addr     = addr_ff;
      mem_ctl.rd_addr     = addr_ff;
      mem_wr.key          = key_ff;
      mem_wr.len          = len_ff;
      mem_wr.value        = value_ff;
      case (state_ff)
         S_CLEAR: begin
            mem_ctl.wr_en       = 1'b1;
            mem_ctl.wr_key_only = 1'b1;
            mem_ctl.wr_addr     = clr_addr_ff;
            mem_wr.key          = '0;
         end
         S_IDLE: begin
            mem_ctl.rd_addr = start_addr;
         end
         S_SCAN: begin
            mem_ctl.rd_addr = next_addr;
            if (cmd_ff == CMD_WRITE && (key_eq || slot_empty)) begin
               mem_ctl.wr_en = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      value_in      = value_ff;
      len_in        = len_ff;
      cap_in        = cap_ff;
      addr_in       = addr_ff;
      slot_in       = slot_ff;
      tbl_in        = tbl_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      res_len_in    = res_len_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_len_in    = rsp_len_ff;

      case (state_ff)
         S_CLEAR: begin
            clr_addr_in = clr_addr_ff + SLOT_AW'(1);
            if (clr_addr_ff == SLOT_AW'(TOTAL_SLOTS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_xfer) begin
               cmd_in        = req_cmd;
               key_in        = req_key;
               len_in        = req_value_len_in[LEN_W-1:0];
               value_in      = req_value_in & byte_mask(req_value_len_in[LEN_W-1:0]);
               cap_in        = req_buffer_capacity;
               addr_in       = start_addr;
               slot_in       = '0;
               tbl_in        = '0;
               res_value_in  = '0;
               res_len_in    = '0;
               if (req_key == '0) begin
                  res_status_in = STS_ZERO_KEY;
                  state_in      = S_DONE;
               end else if (req_cmd == CMD_WRITE &&
                            req_value_len_in > 8'(VALUE_BYTES)) begin
                  res_status_in = STS_TOO_LONG;
                  state_in      = S_DONE;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (cmd_ff == CMD_WRITE) begin
               if (key_eq || slot_empty) begin
                  res_status_in = STS_OK;
                  state_in      = S_DONE;
               end else if (last_slot) begin
                  res_status_in = STS_FULL;
                  state_in      = S_DONE;
               end
            end else begin
               if (slot_empty) begin
                  res_status_in = STS_NOT_FOUND;
                  state_in      = S_DONE;
               end else if (key_eq) begin
                  state_in = S_DONE;
                  if ({4'd0, mem_rd.len} > cap_ff) begin
                     res_status_in = STS_TOO_SMALL;
                  end else begin
                     res_status_in = STS_OK;
                     res_value_in  = mem_rd.value;
                     res_len_in    = mem_rd.len;
                  end
               end else if (last_slot) begin
                  res_status_in = STS_NOT_FOUND;
                  state_in      = S_DONE;
               end
            end
            addr_in = next_addr;
            if (bucket_end) begin
               slot_in = '0;
               tbl_in  = tbl_ff + TBL_CW'(1);
            end else begin
               slot_in = slot_ff + SLOT_CW'(1);
            end
         end
         S_DONE: begin
            // Hand the result over once the output register is free.
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_value_in  = res_value_ff;
               rsp_len_in    = res_len_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      len_ff        <= len_in;
      cap_ff        <= cap_in;
      addr_ff       <= addr_in;
      slot_ff       <= slot_in;
      tbl_ff        <= tbl_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      res_len_ff    <= res_len_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_len_ff    <= rsp_len_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_value_out     = rsp_value_ff;
   assign rsp_value_len_out = rsp_len_ff;

endmodule

[hdl/bkvt_checker.sv]
// Port-level checker of the bucketed key-value table and its bind to the top level.
// Depends on bkvt_pkg and bucketed_key_value_table_top.
module bkvt_checker import bkvt_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [ST_W-1:0]   rsp_status,
   input logic [VAL_W-1:0]  rsp_value_out,
   input logic [LEN_W-1:0]  rsp_value_len_out
);

   // A result that is not taken stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result withdrawn while stalled");

   // Only one request is in work: the block is busy right after a transfer.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while another is in work");

   // Value and length are reported only with a successful status.
   a_zero_on_fail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STS_OK |-> rsp_value_out == '0 &&
      rsp_value_len_out == '0)
      else $error("value reported with a failing status");

   // A returned length never exceeds the stored value size.
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_value_len_out <= LEN_W'(VALUE_BYTES))
      else $error("returned length above value size");

   // Status codes stay within the defined set.
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= STS_ZERO_KEY)
      else $error("undefined status code");

endmodule

bind bucketed_key_value_table_top bkvt_checker u_bkvt_checker (.*);
